// File: rtl/srpp_pkg.sv
`timescale 1ns / 1ps

package srpp_pkg;

    // Sine period; must be a multiple of four (quarter-wave table).
    localparam int STEPS_PER_PERIOD = 400;
    localparam int QTR_STEPS        = STEPS_PER_PERIOD / 4;
    localparam int PHASE_W          = 9;
    localparam int SIN_TAB_LEN      = QTR_STEPS + 1;
    localparam int SIN_IDX_W        = $clog2(SIN_TAB_LEN);
    localparam int SIN_W            = 31;

    localparam int MEAS_W  = 16;
    localparam int GAIN_W  = 17;
    localparam int PEAK_W  = 15;
    localparam int ERR_W   = 18;
    localparam int COEF_W  = 25;
    localparam int PROD_W  = 43;
    localparam int INC_W   = 45;
    localparam int ACC_W   = 48;
    localparam int CMP_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

    // Compare scaling: floor(acc / 256000) = floor((acc >> 11) / 125)
    localparam logic signed [ACC_W-1:0] CMP_LO_ACC = 48'sd7168000;    // 28 * 256000
    localparam logic signed [ACC_W-1:0] CMP_HI_ACC = 48'sd351488000;  // 1373 * 256000
    localparam int                 RECIP_W   = 26;
    localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;          // ceil(2^32 / 125)
    localparam logic [CMP_W-1:0]   CMP_MIN   = 11'd28;
    localparam logic [CMP_W-1:0]   CMP_MAX   = 11'd1372;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK = 2'd3;

    // Pipeline stages
    localparam int NUM_STAGES = 9;
    localparam int ST_IN      = 1;
    localparam int ST_SINE    = 2;
    localparam int ST_SCALE   = 3;
    localparam int ST_ERR     = 4;
    localparam int ST_PROD    = 5;
    localparam int ST_INC     = 6;
    localparam int ST_ACC     = 7;
    localparam int ST_RECIP   = 8;
    localparam int ST_OUT     = 9;

    typedef struct packed {
        logic [NUM_STAGES:1] load;
    } t_pipe_ctl;

    typedef logic [SIN_TAB_LEN-1:0][SIN_W-1:0] t_sin_tab;

    // Q30 sine of rr * (pi/2) / STEPS_PER_PERIOD... scaled quarter angle, Taylor to x^9
    function automatic logic [63:0] sin_q30(input logic [63:0] rr);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        begin
            x  = rr * PI_HALF_Q30 / 64'(STEPS_PER_PERIOD);
            x2 = (x * x) >> 30;
            t  = Q30_ONE - x2 / 64'd72;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
            t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
            return s;
        end
    endfunction

    function automatic t_sin_tab build_sin_tab();
        t_sin_tab tab;
        begin
            for (int k = 0; k < SIN_TAB_LEN; k++) begin
                tab[k] = SIN_W'(sin_q30(64'(4 * k)));
            end
            return tab;
        end
    endfunction

    localparam t_sin_tab SIN_TAB = build_sin_tab();

endpackage

// File: rtl/srpp_sine_ref.sv
`timescale 1ns / 1ps

// Reference generation and error: table lookup, peak scaling, rounding, subtract.
module srpp_sine_ref
    import srpp_pkg::*;
(
    input  logic                     i_clk,
    input  t_pipe_ctl                i_ctl,
    input  logic [PEAK_W-1:0]        i_ref_peak,
    input  logic signed [MEAS_W-1:0] i_meas,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic signed [ERR_W-1:0]  o_err,
    output logic [PHASE_W-1:0]       o_phase
);

    logic [1:0]           w_quad;
    logic [PHASE_W-1:0]   w_m;
    logic [PHASE_W-1:0]   w_k;

    logic [SIN_W-1:0]         r_s2_sin;
    logic                     r_s2_neg;
    logic signed [MEAS_W-1:0] r_s2_meas;
    logic [PHASE_W-1:0]       r_s2_phase;

    logic [45:0]              r_s3_prod;
    logic                     r_s3_neg;
    logic signed [MEAS_W-1:0] r_s3_meas;
    logic [PHASE_W-1:0]       r_s3_phase;

    logic [45:0]              w_rnd;
    logic [PEAK_W-1:0]        w_mag;
    logic signed [ERR_W-1:0]  w_ref;

    logic signed [ERR_W-1:0]  r_s4_err;
    logic [PHASE_W-1:0]       r_s4_phase;

    // quadrant and mirrored quarter-wave index
    always_comb begin
        if (i_phase >= PHASE_W'(3 * QTR_STEPS)) begin
            w_quad = 2'd3;
            w_m    = i_phase - PHASE_W'(3 * QTR_STEPS);
        end else if (i_phase >= PHASE_W'(2 * QTR_STEPS)) begin
            w_quad = 2'd2;
            w_m    = i_phase - PHASE_W'(2 * QTR_STEPS);
        end else if (i_phase >= PHASE_W'(QTR_STEPS)) begin
            w_quad = 2'd1;
            w_m    = i_phase - PHASE_W'(QTR_STEPS);
        end else begin
            w_quad = 2'd0;
            w_m    = i_phase;
        end
        w_k = w_quad[0] ? (PHASE_W'(QTR_STEPS) - w_m) : w_m;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_SINE]) begin
            r_s2_sin   <= SIN_TAB[w_k[SIN_IDX_W-1:0]];
            r_s2_neg   <= w_quad[1];
            r_s2_meas  <= i_meas;
            r_s2_phase <= i_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_SCALE]) begin
            r_s3_prod  <= 46'(r_s2_sin) * 46'(i_ref_peak);
            r_s3_neg   <= r_s2_neg;
            r_s3_meas  <= r_s2_meas;
            r_s3_phase <= r_s2_phase;
        end
    end

    // round half up on the magnitude, then apply half-wave sign
    always_comb begin
        w_rnd = r_s3_prod + (46'd1 << 29);
        w_mag = w_rnd[44:30];
        w_ref = r_s3_neg ? -$signed({3'b000, w_mag}) : $signed({3'b000, w_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_ERR]) begin
            r_s4_err   <= w_ref - ERR_W'(r_s3_meas);
            r_s4_phase <= r_s3_phase;
        end
    end

    assign o_err   = r_s4_err;
    assign o_phase = r_s4_phase;

endmodule

// File: rtl/srpp_pid.sv
`timescale 1ns / 1ps

// Incremental PID: coefficient products, increment sum, saturating accumulator.
module srpp_pid
    import srpp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic [GAIN_W-1:0]       i_kp,
    input  logic [GAIN_W-1:0]       i_ki,
    input  logic [GAIN_W-1:0]       i_kd,
    input  logic signed [ERR_W-1:0] i_err,
    input  logic [PHASE_W-1:0]      i_phase,
    output logic signed [ACC_W-1:0] o_acc,
    output logic [PHASE_W-1:0]      o_phase
);

    logic signed [COEF_W-1:0] r_a0;
    logic signed [COEF_W-1:0] r_a1;
    logic signed [ERR_W-1:0]  r_a2;

    logic signed [ERR_W-1:0]  r_e1;
    logic signed [ERR_W-1:0]  r_e2;

    logic signed [PROD_W-1:0] r_p0;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic [PHASE_W-1:0]       r_s5_phase;

    logic signed [INC_W-1:0]  r_inc;
    logic [PHASE_W-1:0]       r_s6_phase;

    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PHASE_W-1:0]       r_s7_phase;

    // gains in units of 1e-4, refreshed every cycle from the config registers
    always_ff @(posedge i_clk) begin
        r_a0 <= $signed(COEF_W'(i_kp) * COEF_W'(100) + COEF_W'(i_ki) * COEF_W'(10)
                        + COEF_W'(i_kd));
        r_a1 <= -$signed(COEF_W'(i_kp) * COEF_W'(100) + COEF_W'(i_kd) * COEF_W'(2));
        r_a2 <= $signed({1'b0, i_kd});
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_PROD]) begin
            r_p0       <= r_a0 * i_err;
            r_p1       <= r_a1 * r_e1;
            r_p2       <= r_a2 * r_e2;
            r_s5_phase <= i_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1 <= '0;
            r_e2 <= '0;
        end else if (i_ctl.load[ST_PROD]) begin
            r_e1 <= i_err;
            r_e2 <= r_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_INC]) begin
            r_inc      <= INC_W'(r_p0) + INC_W'(r_p1) + INC_W'(r_p2);
            r_s6_phase <= r_s5_phase;
        end
    end

    // saturate to the 48-bit signed range
    always_comb begin
        w_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(r_inc);
        case (w_sum[ACC_W:ACC_W-1])
            2'b01:   n_acc = {1'b0, {(ACC_W-1){1'b1}}};
            2'b10:   n_acc = {1'b1, {(ACC_W-1){1'b0}}};
            default: n_acc = w_sum[ACC_W-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.load[ST_ACC]) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_ACC]) begin
            r_s7_phase <= r_s6_phase;
        end
    end

    assign o_acc   = r_acc;
    assign o_phase = r_s7_phase;

endmodule

// File: rtl/srpp_pwm_scale.sv
`timescale 1ns / 1ps

// PWM compare: clamp and divide the accumulator by 256000 (shift, then x/125).
module srpp_pwm_scale
    import srpp_pkg::*;
(
    input  logic                    i_clk,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic [PHASE_W-1:0]      i_phase,
    output logic [CMP_W-1:0]        o_compare,
    output logic [PHASE_W-1:0]      o_phase
);

    localparam int X_W  = 18;
    localparam int RP_W = X_W + RECIP_W;

    logic               r_lo;
    logic               r_hi;
    logic [RP_W-1:0]    r_rprod;
    logic [PHASE_W-1:0] r_s8_phase;

    logic [CMP_W-1:0]   w_q;
    logic [CMP_W-1:0]   r_cmp;
    logic [PHASE_W-1:0] r_s9_phase;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_RECIP]) begin
            r_lo       <= i_acc < CMP_LO_ACC;
            r_hi       <= i_acc >= CMP_HI_ACC;
            // in range the accumulator stays below 2^29
            r_rprod    <= RP_W'(i_acc[X_W+10:11]) * RP_W'(RECIP_125);
            r_s8_phase <= i_phase;
        end
    end

    assign w_q = r_rprod[32+CMP_W-1:32];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[ST_OUT]) begin
            if (r_lo) begin
                r_cmp <= CMP_MIN;
            end else if (r_hi) begin
                r_cmp <= CMP_MAX;
            end else begin
                r_cmp <= w_q;
            end
            r_s9_phase <= r_s8_phase;
        end
    end

    assign o_compare = r_cmp;
    assign o_phase   = r_s9_phase;

endmodule

// File: rtl/sine_reference_pid_pwm.sv
`timescale 1ns / 1ps

// Sine-reference voltage loop: incremental PID driving a PWM compare value.
//
// Input channel (i_valid / o_ready): one measured voltage sample, Q8.8 signed,
// per control tick. Output channel (o_valid / i_ready): the PWM compare value
// (28..1372) and the sine phase index used for that tick. Config channel
// (i_cfg_valid / o_cfg_ready, always ready): index 0 Kp, 1 Ki, 2 Kd, 3 peak.
//
// Throughput: one request per cycle while the receiver keeps up, set by the
// 9-stage pipeline with the saturating accumulator loop in stage 7.
//
// Each stage has its own valid bit and advances when the next stage is empty
// or moving, so a stalled receiver only fills the pipeline; o_ready stays high
// until all nine stages hold requests. Bubbles are squeezed out.
//
// Reset clears the phase counter, the error history, the accumulator, the
// valid bits, and loads the gain defaults (Kp 1.00, Ki 0, Kd 0, peak 8688).
module sine_reference_pid_pwm
    import srpp_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [MEAS_W-1:0] i_measured_volts,

    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [CMP_W-1:0]         o_pwm_compare,
    output logic [PHASE_W-1:0]       o_phase_step,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [GAIN_W-1:0]        i_cfg_data
);

    // config registers
    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;
    logic [GAIN_W-1:0] r_kd;
    logic [PEAK_W-1:0] r_peak;

    // pipeline control
    logic [NUM_STAGES:1] r_valid;
    logic [NUM_STAGES:1] n_valid;
    logic [NUM_STAGES:1] w_en;
    t_pipe_ctl           w_ctl;

    // phase counter and input stage
    logic [PHASE_W-1:0]       r_phase;
    logic signed [MEAS_W-1:0] r_s1_meas;
    logic [PHASE_W-1:0]       r_s1_phase;

    logic signed [ERR_W-1:0]  w_err;
    logic [PHASE_W-1:0]       w_err_phase;
    logic signed [ACC_W-1:0]  w_acc;
    logic [PHASE_W-1:0]       w_acc_phase;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= GAIN_W'(100);
            r_ki   <= '0;
            r_kd   <= '0;
            r_peak <= PEAK_W'(8688);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KP:   r_kp   <= i_cfg_data;
                CFG_KI:   r_ki   <= i_cfg_data;
                CFG_KD:   r_kd   <= i_cfg_data;
                CFG_PEAK: r_peak <= i_cfg_data[PEAK_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    always_comb begin
        w_en[NUM_STAGES] = !r_valid[NUM_STAGES] || i_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        w_ctl.load[ST_IN] = i_valid && w_en[ST_IN];
        n_valid[ST_IN]    = w_en[ST_IN] ? i_valid : r_valid[ST_IN];
        for (int k = 2; k <= NUM_STAGES; k++) begin
            w_ctl.load[k] = r_valid[k-1] && w_en[k];
            n_valid[k]    = w_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = w_en[ST_IN];
    assign o_valid = r_valid[ST_OUT];

    // phase advances once per accepted request, wrapping at the period
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_ctl.load[ST_IN]) begin
            r_phase <= (r_phase == PHASE_W'(STEPS_PER_PERIOD - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load[ST_IN]) begin
            r_s1_meas  <= i_measured_volts;
            r_s1_phase <= r_phase;
        end
    end

    srpp_sine_ref u_sine_ref (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_ref_peak (r_peak),
        .i_meas     (r_s1_meas),
        .i_phase    (r_s1_phase),
        .o_err      (w_err),
        .o_phase    (w_err_phase)
    );

    srpp_pid u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_kp    (r_kp),
        .i_ki    (r_ki),
        .i_kd    (r_kd),
        .i_err   (w_err),
        .i_phase (w_err_phase),
        .o_acc   (w_acc),
        .o_phase (w_acc_phase)
    );

    srpp_pwm_scale u_pwm_scale (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_acc     (w_acc),
        .i_phase   (w_acc_phase),
        .o_compare (o_pwm_compare),
        .o_phase   (o_phase_step)
    );

    // compare value always inside the clamp window
    a_cmp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pwm_compare >= CMP_MIN) && (o_pwm_compare <= CMP_MAX))
        else $error("pwm compare out of range");

    // reported phase always inside one period
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_phase_step < PHASE_W'(STEPS_PER_PERIOD)))
        else $error("phase step out of range");

    // a draining output never blocks intake
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("intake blocked while output drains");

    // phase counter steps by one per accepted request
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load[ST_IN] |=>
            (r_phase == (($past(r_phase) == PHASE_W'(STEPS_PER_PERIOD - 1)) ?
                         PHASE_W'(0) : PHASE_W'($past(r_phase) + 1'b1))))
        else $error("phase counter did not advance");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the sine-reference PID / PWM voltage loop.
module tb_top;
    import srpp_pkg::*;

    // Quarter-wave angle step numerator, pi/2 in Q30
    localparam logic [63:0] ANGLE_QTR_Q30 = 64'd1686629713;
    localparam logic [63:0] UNIT_Q30      = 64'd1 << 30;
    localparam longint      TICK_SCALE    = 256000;          // acc units per compare count
    localparam longint      ACC_TOP       = 64'sd140737488355327;
    localparam longint      ACC_BOTTOM    = -64'sd140737488355328;
    localparam longint      CMP_FLOOR     = 28;
    localparam longint      CMP_CEIL      = 1372;
    localparam logic [GAIN_W-1:0] GAIN_ALL_ONES = '1;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int          PHASE_ITEMS   = 100;
    localparam int          PUMP_CAP      = 400;
    localparam int          DRAIN_CYCLES  = 2 * NUM_STAGES;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic [CMP_W-1:0]   compare;
        logic [PHASE_W-1:0] phase;
    } t_pwm_tick;

    // Voltage loop model: gains, sine phase, error history and accumulator.
    // note_sample() runs one control tick per accepted request and queues
    // the expected tick; check_tick() pops it against the block's output.
    class voltage_loop_model;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [PEAK_W-1:0] peak;
        int unsigned       phase;
        int                err_last;
        int                err_prev;
        longint            acc;
        t_pwm_tick         expected_ticks[$];
        int unsigned       errors;
        int unsigned       ticks_checked;
        int unsigned       hits_top;
        int unsigned       hits_bottom;
        int unsigned       clamps_low;
        int unsigned       clamps_high;

        function new();
            kp = 100;
            ki = 0;
            kd = 0;
            peak = 8688;
            phase = 0;
            err_last = 0;
            err_prev = 0;
            acc = 0;
            errors = 0;
            ticks_checked = 0;
            hits_top = 0;
            hits_bottom = 0;
            clamps_low = 0;
            clamps_high = 0;
        endfunction

        // Sine of 2*pi*p/period times peak, Q8.8, from a Q30 Taylor series
        function int sine_point(int unsigned p);
            logic [63:0] quad;
            logic [63:0] rem;
            logic [63:0] rr;
            logic [63:0] x;
            logic [63:0] x2;
            logic [63:0] t;
            logic [63:0] s;
            logic [63:0] mag;
            quad = (64'(p) * 64'd4) / 64'(STEPS_PER_PERIOD);
            rem  = (64'(p) * 64'd4) % 64'(STEPS_PER_PERIOD);
            // odd quadrants run back down the quarter wave
            rr   = quad[0] ? 64'(STEPS_PER_PERIOD) - rem : rem;
            x    = rr * ANGLE_QTR_Q30 / 64'(STEPS_PER_PERIOD);
            x2   = (x * x) >> 30;
            t    = UNIT_Q30 - x2 / 64'd72;
            t    = UNIT_Q30 - ((x2 * t) >> 30) / 64'd42;
            t    = UNIT_Q30 - ((x2 * t) >> 30) / 64'd20;
            t    = UNIT_Q30 - ((x2 * t) >> 30) / 64'd6;
            s    = (x * t) >> 30;
            if (s > UNIT_Q30) begin
                s = UNIT_Q30;
            end
            mag  = (s * 64'(peak) + (64'd1 << 29)) >> 30;
            return (quad >= 2) ? -int'(mag) : int'(mag);
        endfunction

        function int next_reference();
            return sine_point(phase);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
            case (idx)
                CFG_KP:   kp = data;
                CFG_KI:   ki = data;
                CFG_KD:   kd = data;
                CFG_PEAK: peak = data[PEAK_W-1:0];
                default:  ;
            endcase
        endfunction

        function void note_sample(logic signed [MEAS_W-1:0] volts);
            int        e;
            longint    a0;
            longint    a1;
            longint    a2;
            longint    sum;
            longint    cmp;
            t_pwm_tick tick;
            e   = next_reference() - int'(volts);
            a0  = 100 * longint'(kp) + 10 * longint'(ki) + longint'(kd);
            a1  = -(100 * longint'(kp) + 2 * longint'(kd));
            a2  = longint'(kd);
            sum = acc + a0 * e + a1 * err_last + a2 * err_prev;
            if (sum > ACC_TOP) begin
                sum = ACC_TOP;
            end
            if (sum < ACC_BOTTOM) begin
                sum = ACC_BOTTOM;
            end
            if (sum == ACC_TOP) hits_top++;
            if (sum == ACC_BOTTOM) hits_bottom++;
            acc      = sum;
            err_prev = err_last;
            err_last = e;
            if (sum < CMP_FLOOR * TICK_SCALE) begin
                cmp = CMP_FLOOR;
                clamps_low++;
            end else if (sum >= (CMP_CEIL + 1) * TICK_SCALE) begin
                cmp = CMP_CEIL;
                clamps_high++;
            end else begin
                cmp = sum / TICK_SCALE;
            end
            tick.compare = CMP_W'(cmp);
            tick.phase   = PHASE_W'(phase);
            expected_ticks.push_back(tick);
            phase = (phase + 1 >= STEPS_PER_PERIOD) ? 0 : phase + 1;
        endfunction

        function void check_tick(logic [CMP_W-1:0] compare, logic [PHASE_W-1:0] ph);
            t_pwm_tick want;
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got compare %0d phase %0d",
                         $time, compare, ph);
                return;
            end
            want = expected_ticks.pop_front();
            ticks_checked++;
            if (compare !== want.compare) begin
                errors++;
                $display("%0t: pwm_compare mismatch, expected %0d, got %0d",
                         $time, want.compare, compare);
            end
            if (ph !== want.phase) begin
                errors++;
                $display("%0t: phase_step mismatch, expected %0d, got %0d",
                         $time, want.phase, ph);
            end
        endfunction

        function int unsigned pending();
            return expected_ticks.size();
        endfunction

        function bit acc_pinned(bit upward);
            return acc == (upward ? ACC_TOP : ACC_BOTTOM);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [MEAS_W-1:0] i_measured_volts;
    logic                     o_valid;
    logic                     i_ready;
    logic [CMP_W-1:0]         o_pwm_compare;
    logic [PHASE_W-1:0]       o_phase_step;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [GAIN_W-1:0]        i_cfg_data;

    voltage_loop_model model;
    int unsigned       cycle_count = 0;
    int unsigned       reg_writes  = 0;
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;

    sine_reference_pid_pwm u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_measured_volts (i_measured_volts),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pwm_compare    (o_pwm_compare),
        .o_phase_step     (o_phase_step),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: ends a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, model.pending());
            $display("** sine_reference_pid_pwm: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle on the falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result monitor: every accepted tick is checked against the model
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            model.check_tick(o_pwm_compare, o_phase_step);
        end
    end

    task automatic set_idle_mode(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 69; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default:   begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    function automatic logic signed [MEAS_W-1:0] clamp_sample(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return MEAS_W'(v);
    endfunction

    // Mostly samples that track the reference with a bounded error, so the
    // compare value moves through its range; the rest is full-scale noise.
    function automatic logic signed [MEAS_W-1:0] tracking_sample();
        if ($urandom_range(0, 99) < 30) begin
            return MEAS_W'($urandom());
        end
        return clamp_sample(model.next_reference() - (int'($urandom_range(0, 9000)) - 1500));
    endfunction

    // One sample request. Entered on a falling edge; valid holds with a fixed
    // payload until the handshake, then control returns on the next falling
    // edge with valid still high so a back-to-back request needs no drop.
    task automatic send_sample(input logic signed [MEAS_W-1:0] volts);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_measured_volts <= volts;
        do @(posedge i_clk); while (!o_ready);
        model.note_sample(volts);
        @(negedge i_clk);
    endtask

    // Register write, only once every outstanding tick has drained out
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
        i_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.set_register(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure_loop(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] peak);
        write_reg(CFG_KP, kp);
        write_reg(CFG_KI, ki);
        write_reg(CFG_KD, kd);
        write_reg(CFG_PEAK, peak);
    endtask

    // Drive the accumulator into saturation. With Ki = Kd = 0 the increment
    // is Kp*(e - e1); toggling Kp between max and zero around an error swing
    // ratchets the accumulator one way since the return swing adds nothing.
    task automatic pump_accumulator(input bit upward);
        int left;
        left = 4;   // extra rounds held at the rail
        configure_loop(0, 0, 0, 0);
        for (int n = 0; n < PUMP_CAP && left > 0; n++) begin
            write_reg(CFG_KP, GAIN_ALL_ONES);
            send_sample(upward ? clamp_sample(-32768 + int'($urandom_range(0, 15)))
                               : clamp_sample(32767 - int'($urandom_range(0, 15))));
            write_reg(CFG_KP, '0);
            send_sample(upward ? clamp_sample(32767 - int'($urandom_range(0, 15)))
                               : clamp_sample(-32768 + int'($urandom_range(0, 15))));
            if (model.acc_pinned(upward)) begin
                left--;
            end
        end
    endtask

    initial begin
        model            = new();
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_measured_volts = '0;
        i_ready          = 1'b1;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset gains: full-scale and pattern samples, then errors
        // straddling both compare clamps and a negative error
        set_idle_mode(IDLE_NONE);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sh5555);
        send_sample(-16'sh5556);
        send_sample(16'sh0001);
        send_sample(-16'sh0001);
        send_sample(clamp_sample(model.next_reference() - 1000));
        send_sample(clamp_sample(model.next_reference() - 10000));
        send_sample(clamp_sample(model.next_reference() - 30000));
        send_sample(clamp_sample(model.next_reference() + 5000));
        send_sample(clamp_sample(model.next_reference() - 716));
        send_sample(clamp_sample(model.next_reference() - 717));
        send_sample(clamp_sample(model.next_reference() - 35148));
        send_sample(clamp_sample(model.next_reference() - 35149));

        // Random phases, each with its own gain set and idle pattern. Gains
        // change mid-stream and the loop state carries across.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: configure_loop(100, 0, 0, 8688);
                1: configure_loop(256, 5, 3, 32767);
                2: configure_loop(0, 0, 0, 0);
                3: configure_loop(1000, 100, 1000, GAIN_ALL_ONES);   // peak masked
                4: configure_loop(99999, 99999, 99999, 32767);
                5: configure_loop(GAIN_ALL_ONES, GAIN_ALL_ONES, GAIN_ALL_ONES, 20000);
                6: configure_loop(GAIN_W'($urandom_range(0, 500)),
                                  GAIN_W'($urandom_range(0, 200)),
                                  GAIN_W'($urandom_range(0, 2000)),
                                  GAIN_W'($urandom_range(0, 32767)));
                default: configure_loop(GAIN_W'($urandom()), GAIN_W'($urandom()),
                                        GAIN_W'($urandom()), GAIN_W'($urandom()));
            endcase
            set_idle_mode(t_idle_mode'(p % 4));
            repeat (PHASE_ITEMS) send_sample(tracking_sample());
        end

        // Accumulator to the positive rail, then all the way to the negative
        set_idle_mode(IDLE_BOTH);
        pump_accumulator(1'b1);
        set_idle_mode(IDLE_RECV);
        pump_accumulator(1'b0);

        // Wind-down at reset-like gains, then drain
        configure_loop(100, 10, 50, 8688);
        set_idle_mode(IDLE_SEND);
        repeat (20) send_sample(tracking_sample());
        i_valid <= 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("checked %0d ticks over %0d register writes; compare clamped low %0d, high %0d",
                 model.ticks_checked, reg_writes, model.clamps_low, model.clamps_high);
        $display("accumulator held at positive rail %0d ticks, negative rail %0d ticks",
                 model.hits_top, model.hits_bottom);
        if (model.errors == 0) begin
            $display("** sine_reference_pid_pwm: PASSED **");
        end else begin
            $display("** sine_reference_pid_pwm: FAILED **");
        end
        $finish;
    end

endmodule

// File: sine_reference_pid_pwm.f
rtl/srpp_pkg.sv
rtl/srpp_sine_ref.sv
rtl/srpp_pid.sv
rtl/srpp_pwm_scale.sv
rtl/sine_reference_pid_pwm.sv
verif/tb_top.sv
